/* hw/rtl/mbrx_pkg.sv */
// ----------------------------------------------------------------------------
// Modbus RTU receiver package
// Shared types, constants and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbrx_pkg;

    localparam int BUFFER_BYTES    = 256;
    localparam int FUNCTION_LIMIT  = 63;
    localparam int MIN_FRAME_BYTES = 4;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 64;

    localparam logic [7:0]  BROADCAST_ADDR = 8'h00;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  SLAVE_ADDR_RST = 8'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SLAVE_ADDRESS       = 2'd0,
        REG_SUPPORTED_FUNCTIONS = 2'd1
    } t_reg_index;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_GAP  = 2'd1,
        CMD_POLL = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OUT_NONE     = 3'd0,
        OUT_ACCEPT   = 3'd1,
        OUT_CRC_ERR  = 3'd2,
        OUT_BAD_FUNC = 3'd3,
        OUT_DROP     = 3'd4
    } t_outcome;

    typedef struct packed {
        t_cmd       kind;
        logic [7:0] data;
    } t_op;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/mbrx_if.sv */
// ----------------------------------------------------------------------------
// Modbus RTU receiver channels
// Command, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mbrx_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface mbrx_res_if;
    logic               valid;
    logic               ready;
    mbrx_pkg::t_outcome outcome;
    logic [7:0]         device_address;
    logic [7:0]         function_code;
    logic [7:0]         frame_length;
    logic               broadcast;

    modport source (output valid, output outcome, output device_address,
                    output function_code, output frame_length, output broadcast,
                    input ready);
    modport sink (input valid, input outcome, input device_address,
                  input function_code, input frame_length, input broadcast,
                  output ready);
endinterface

interface mbrx_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mbrx_pkg::CFG_INDEX_W-1:0] index;
    logic [mbrx_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mbrx_front.sv */
// ----------------------------------------------------------------------------
// Modbus RTU receiver front end
// Accepts command items, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbrx_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    mbrx_cmd_if.sink           i_cmd,
    output mbrx_pkg::t_op      o_op,
    output logic               o_op_valid,
    input  wire logic          i_op_ready
);

    mbrx_pkg::t_op r_slot [2];
    logic          r_wr_ptr, n_wr_ptr;
    logic          r_rd_ptr, n_rd_ptr;
    logic [1:0]    r_count, n_count;

    mbrx_pkg::t_op w_op;
    logic          w_push;
    logic          w_pop;

    always_comb begin
        w_op.kind = mbrx_pkg::t_cmd'(i_cmd.command);
        w_op.data = (w_op.kind == mbrx_pkg::CMD_BYTE) ? i_cmd.data_byte : 8'h00;
    end

    assign i_cmd.ready = (r_count != 2'd2);
    assign o_op_valid  = (r_count != 2'd0);
    assign o_op        = r_slot[r_rd_ptr];
    assign w_push      = i_cmd.valid && i_cmd.ready;
    assign w_pop       = o_op_valid && i_op_ready;

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_op;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("front queue count out of range");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("front queue pointers disagree with count");

endmodule

`default_nettype wire

/* hw/rtl/mbrx_back.sv */
// ----------------------------------------------------------------------------
// Modbus RTU receiver back end
// Runs the framing state, CRC and classification, and registers each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbrx_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mbrx_pkg::t_op i_op,
    input  wire logic          i_op_valid,
    output logic               o_op_ready,
    mbrx_cfg_if.sink           i_cfg,
    mbrx_res_if.source         o_res
);

    localparam logic [7:0] LastSlot = 8'(mbrx_pkg::BUFFER_BYTES - 1);
    localparam logic [7:0] MinLen   = 8'(mbrx_pkg::MIN_FRAME_BYTES);
    localparam logic [7:0] FuncMax  = 8'(mbrx_pkg::FUNCTION_LIMIT);

    logic [7:0]                      r_slave_addr;
    logic [mbrx_pkg::CFG_DATA_W-1:0] r_supported;

    logic        r_frame_pending, n_frame_pending;
    logic [7:0]  r_byte_count, n_byte_count;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_cap_addr, n_cap_addr;
    logic [7:0]  r_cap_func, n_cap_func;

    logic               r_out_valid;
    mbrx_pkg::t_outcome r_outcome, n_outcome;
    logic [7:0]         r_out_addr, n_out_addr;
    logic [7:0]         r_out_func, n_out_func;
    logic [7:0]         r_out_len, n_out_len;
    logic               r_out_bcast, n_out_bcast;

    logic w_take;
    logic w_func_ok;

    assign o_op_ready = !r_out_valid || o_res.ready;
    assign w_take     = i_op_valid && o_op_ready;
    assign i_cfg.ready = 1'b1;

    assign w_func_ok = (r_cap_func <= FuncMax) && r_supported[r_cap_func[5:0]];

    always_comb begin
        n_frame_pending = r_frame_pending;
        n_byte_count    = r_byte_count;
        n_crc           = r_crc;
        n_cap_addr      = r_cap_addr;
        n_cap_func      = r_cap_func;
        n_outcome       = mbrx_pkg::OUT_NONE;
        n_out_addr      = 8'h00;
        n_out_func      = 8'h00;
        n_out_len       = 8'h00;
        n_out_bcast     = 1'b0;
        case (i_op.kind)
            mbrx_pkg::CMD_BYTE: begin
                if (!r_frame_pending) begin
                    if (r_byte_count < LastSlot) begin
                        if (r_byte_count == 8'd0) begin
                            n_cap_addr = i_op.data;
                        end else if (r_byte_count == 8'd1) begin
                            n_cap_func = i_op.data;
                        end
                        n_crc        = mbrx_pkg::crc16_byte(r_crc, i_op.data);
                        n_byte_count = r_byte_count + 8'd1;
                    end else begin
                        n_frame_pending = 1'b1;
                    end
                end
            end
            mbrx_pkg::CMD_GAP: begin
                n_frame_pending = 1'b1;
            end
            mbrx_pkg::CMD_POLL: begin
                if (r_frame_pending) begin
                    n_out_addr  = r_cap_addr;
                    n_out_func  = r_cap_func;
                    n_out_len   = r_byte_count;
                    n_out_bcast = (r_byte_count != 8'd0) &&
                                  (r_cap_addr == mbrx_pkg::BROADCAST_ADDR);
                    if (r_byte_count < MinLen) begin
                        n_outcome = mbrx_pkg::OUT_DROP;
                    end else if (r_cap_addr != r_slave_addr &&
                                 r_cap_addr != mbrx_pkg::BROADCAST_ADDR) begin
                        n_outcome = mbrx_pkg::OUT_DROP;
                    end else if (!w_func_ok) begin
                        n_outcome = mbrx_pkg::OUT_BAD_FUNC;
                    end else if (r_crc != 16'h0000) begin
                        n_outcome = mbrx_pkg::OUT_CRC_ERR;
                    end else begin
                        n_outcome = mbrx_pkg::OUT_ACCEPT;
                    end
                    n_frame_pending = 1'b0;
                    n_byte_count    = 8'd0;
                    n_crc           = mbrx_pkg::CRC_INIT;
                    n_cap_addr      = 8'h00;
                    n_cap_func      = 8'h00;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= mbrx_pkg::SLAVE_ADDR_RST;
            r_supported  <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                mbrx_pkg::REG_SLAVE_ADDRESS: begin
                    r_slave_addr <= i_cfg.data[7:0];
                end
                mbrx_pkg::REG_SUPPORTED_FUNCTIONS: begin
                    r_supported <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pending <= 1'b0;
            r_byte_count    <= 8'd0;
            r_crc           <= mbrx_pkg::CRC_INIT;
            r_cap_addr      <= 8'h00;
            r_cap_func      <= 8'h00;
            r_out_valid     <= 1'b0;
        end else begin
            if (w_take) begin
                r_frame_pending <= n_frame_pending;
                r_byte_count    <= n_byte_count;
                r_crc           <= n_crc;
                r_cap_addr      <= n_cap_addr;
                r_cap_func      <= n_cap_func;
                r_out_valid     <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_outcome   <= n_outcome;
            r_out_addr  <= n_out_addr;
            r_out_func  <= n_out_func;
            r_out_len   <= n_out_len;
            r_out_bcast <= n_out_bcast;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.outcome        = r_outcome;
    assign o_res.device_address = r_out_addr;
    assign o_res.function_code  = r_out_func;
    assign o_res.frame_length   = r_out_len;
    assign o_res.broadcast      = r_out_bcast;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= LastSlot)
        else $error("byte count past buffer end");

    a_poll_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_op.kind == mbrx_pkg::CMD_POLL && r_frame_pending) |=>
        (!r_frame_pending && r_byte_count == 8'd0 && r_crc == mbrx_pkg::CRC_INIT))
        else $error("poll of a pending frame did not clear the receiver");

    a_accept_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_outcome == mbrx_pkg::OUT_ACCEPT) |-> (r_out_len >= MinLen))
        else $error("accepted frame shorter than minimum");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_outcome == mbrx_pkg::OUT_NONE) |->
        (r_out_addr == 8'h00 && r_out_func == 8'h00 && r_out_len == 8'h00 && !r_out_bcast))
        else $error("empty result carries frame fields");

endmodule

`default_nettype wire

/* hw/rtl/modbus_rtu_frame_receiver.sv */
// ----------------------------------------------------------------------------
// Modbus RTU frame receiver
// Collects received bytes into a frame, checks its CRC-16 and classifies it.
//
// The command channel carries one item per received byte, gap timeout or poll.
// Every accepted item yields exactly one result item on the result channel;
// only a poll of a pending frame yields a classification, all others report
// nothing. The configuration channel is always ready and writes the slave
// address (index 0) or the supported function mask (index 1).
// An accepted item waits in the front queue until the back end takes it, and its
// result is registered there and held on the result channel until it is taken.
// One item per cycle is sustained while the result channel is ready,
// with the byte-wide CRC and framing update in the back end.
// Reset clears the framing state, sets the slave address to 1 and clears the
// function mask. When the result channel stalls, the result register holds its
// item, the two-entry command queue fills, and the command channel drops ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_frame_receiver (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mbrx_cmd_if.sink   i_cmd,
    mbrx_cfg_if.sink   i_cfg,
    mbrx_res_if.source o_res
);

    mbrx_pkg::t_op w_op;
    logic          w_op_valid;
    logic          w_op_ready;

    mbrx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .o_op       (w_op),
        .o_op_valid (w_op_valid),
        .i_op_ready (w_op_ready)
    );

    mbrx_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_op),
        .i_op_valid (w_op_valid),
        .o_op_ready (w_op_ready),
        .i_cfg      (i_cfg),
        .o_res      (o_res)
    );

endmodule

`default_nettype wire

/* tb/sv/modbus_rtu_frame_receiver_test.sv */
// ----------------------------------------------------------------------------
// Modbus RTU frame receiver testbench
// Sends received bytes, gap timeouts and polls through the command channel and
// checks every result item against a cycle-free prediction of the framer,
// under random sender idling and result stalls and several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modbus_rtu_frame_receiver_test;

    import mbrx_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 240;

    typedef struct {
        t_op op;
        bit  drain_first;
    } t_queued_op;

    typedef struct {
        t_outcome   outcome;
        logic [7:0] address;
        logic [7:0] func;
        logic [7:0] length;
        logic       bcast;
    } t_frame_result;

    logic i_clk;
    logic i_rst_n;

    mbrx_cmd_if cmd_ch ();
    mbrx_cfg_if cfg_ch ();
    mbrx_res_if res_ch ();

    modbus_rtu_frame_receiver uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    t_queued_op    pending_ops[$];
    t_frame_result expected_results[$];

    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          error_count;
    int          items_queued;
    bit          drain_next;

    logic [7:0]  model_slave_addr;
    logic [63:0] model_func_mask;
    bit          fr_pending;
    int          fr_count;
    logic [15:0] fr_crc;
    logic [7:0]  fr_addr;
    logic [7:0]  fr_func;
    t_op         current_op;

    function automatic logic [15:0] crc16_modbus(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        acc = crc ^ {8'h00, b};
        repeat (8) begin
            if (acc[0]) begin
                acc = {1'b0, acc[15:1]} ^ 16'hA001;
            end else begin
                acc = {1'b0, acc[15:1]};
            end
        end
        return acc;
    endfunction

    task automatic clear_framer();
        fr_pending = 1'b0;
        fr_count   = 0;
        fr_crc     = 16'hFFFF;
        fr_addr    = 8'h00;
        fr_func    = 8'h00;
    endtask

    task automatic frame_step(input t_op op);
        t_frame_result r;
        r.outcome = OUT_NONE;
        r.address = 8'h00;
        r.func    = 8'h00;
        r.length  = 8'h00;
        r.bcast   = 1'b0;
        case (op.kind)
            CMD_BYTE: begin
                if (!fr_pending) begin
                    if (fr_count < BUFFER_BYTES - 1) begin
                        if (fr_count == 0) begin
                            fr_addr = op.data;
                        end else if (fr_count == 1) begin
                            fr_func = op.data;
                        end
                        fr_crc   = crc16_modbus(fr_crc, op.data);
                        fr_count = fr_count + 1;
                    end else begin
                        fr_pending = 1'b1;
                    end
                end
            end
            CMD_GAP: begin
                fr_pending = 1'b1;
            end
            CMD_POLL: begin
                if (fr_pending) begin
                    r.address = fr_addr;
                    r.func    = fr_func;
                    r.length  = fr_count[7:0];
                    r.bcast   = (fr_count >= 1) && (fr_addr == BROADCAST_ADDR);
                    if (fr_count < MIN_FRAME_BYTES) begin
                        r.outcome = OUT_DROP;
                    end else if (fr_addr != model_slave_addr && fr_addr != BROADCAST_ADDR) begin
                        r.outcome = OUT_DROP;
                    end else if (fr_func > FUNCTION_LIMIT) begin
                        r.outcome = OUT_BAD_FUNC;
                    end else if (!model_func_mask[fr_func[5:0]]) begin
                        r.outcome = OUT_BAD_FUNC;
                    end else if (fr_crc != 16'h0000) begin
                        r.outcome = OUT_CRC_ERR;
                    end else begin
                        r.outcome = OUT_ACCEPT;
                    end
                    clear_framer();
                end
            end
            default: begin
            end
        endcase
        expected_results.push_back(r);
    endtask

    task automatic push_op(input t_cmd kind, input logic [7:0] data);
        t_queued_op q;
        q.op.kind     = kind;
        q.op.data     = data;
        q.drain_first = drain_next;
        drain_next    = 1'b0;
        pending_ops.push_back(q);
        items_queued++;
    endtask

    // corrupt: 0 keeps the frame intact, 1 flips a bit anywhere, 2 flips a CRC bit.
    // A set overflow ends the frame with one byte too many instead of a gap.
    task automatic queue_frame(input logic [7:0] addr, input logic [7:0] func, input int payload,
                               input int corrupt, input int noise, input bit overflow);
        logic [7:0]  bytes[$];
        logic [15:0] c;
        int          pos;
        bytes.push_back(addr);
        bytes.push_back(func);
        repeat (payload) bytes.push_back(8'($urandom));
        c = 16'hFFFF;
        foreach (bytes[i]) c = crc16_modbus(c, bytes[i]);
        bytes.push_back(c[7:0]);
        bytes.push_back(c[15:8]);
        if (corrupt == 1) begin
            pos = $urandom_range(bytes.size() - 1);
            bytes[pos] = bytes[pos] ^ (8'h01 << $urandom_range(7));
        end else if (corrupt == 2) begin
            pos = bytes.size() - 1 - $urandom_range(1);
            bytes[pos] = bytes[pos] ^ (8'h01 << $urandom_range(7));
        end
        foreach (bytes[i]) push_op(CMD_BYTE, bytes[i]);
        if (overflow) begin
            push_op(CMD_BYTE, 8'($urandom));
        end else begin
            push_op(CMD_GAP, 8'($urandom));
        end
        repeat (noise) push_op($urandom_range(1) ? CMD_BYTE : CMD_GAP, 8'($urandom));
        push_op(CMD_POLL, 8'($urandom));
    endtask

    task automatic queue_random_frame();
        int         sel;
        int         r;
        logic [7:0] addr;
        logic [7:0] func;
        r = $urandom_range(99);
        if (r < 55) begin
            addr = model_slave_addr;
        end else if (r < 75) begin
            addr = BROADCAST_ADDR;
        end else begin
            addr = 8'($urandom);
        end
        r = $urandom_range(99);
        if (r < 60) begin
            func = 8'($urandom_range(FUNCTION_LIMIT));
        end else if (r < 75) begin
            func = $urandom_range(1) ? 8'(FUNCTION_LIMIT) : 8'h00;
        end else if (r < 85) begin
            func = 8'(FUNCTION_LIMIT + 1);
        end else begin
            func = 8'($urandom_range(255, FUNCTION_LIMIT + 1));
        end
        sel = $urandom_range(99);
        if (sel < 60) begin
            queue_frame(addr, func, $urandom_range(4), 0, ($urandom_range(9) == 0), 1'b0);
        end else if (sel < 72) begin
            queue_frame(addr, func, $urandom_range(4), $urandom_range(2, 1), 0, 1'b0);
        end else if (sel < 82) begin
            repeat ($urandom_range(3)) push_op(CMD_BYTE, 8'($urandom));
            push_op(CMD_GAP, 8'($urandom));
            push_op(CMD_POLL, 8'($urandom));
        end else if (sel < 92) begin
            repeat ($urandom_range(3, 1)) push_op(t_cmd'($urandom_range(3)), 8'($urandom));
            push_op(CMD_GAP, 8'($urandom));
            push_op(CMD_POLL, 8'($urandom));
        end else begin
            push_op($urandom_range(1) ? CMD_POLL : CMD_NONE, 8'($urandom));
        end
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [63:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do begin
            @(posedge i_clk);
        end while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_SLAVE_ADDRESS) begin
            model_slave_addr = value[7:0];
        end else begin
            model_func_mask = value;
        end
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || cmd_ch.valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic run_random_phase(input int sender_pct, input int receiver_pct,
                                    input bit with_long);
        int goal;
        int long_at;
        goal               = items_queued + PHASE_ITEMS;
        long_at            = items_queued + $urandom_range(PHASE_ITEMS - 20);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
        while (items_queued < goal) begin
            if (with_long && items_queued >= long_at) begin
                queue_frame(model_slave_addr, 8'($urandom_range(FUNCTION_LIMIT)),
                            BUFFER_BYTES - 3, $urandom_range(1) * 2, 0, 1'b1);
                with_long = 1'b0;
            end
            if ($urandom_range(49) == 0) begin
                drain_next = 1'b1;
            end
            queue_random_frame();
        end
        wait_drained();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("modbus_rtu_frame_receiver test failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                frame_step(current_op);
            end
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (pending_ops.size() != 0
                        && (!pending_ops[0].drain_first || expected_results.size() == 0)
                        && $urandom_range(99) >= sender_idle_pct) begin
                    current_op        = pending_ops[0].op;
                    void'(pending_ops.pop_front());
                    cmd_ch.valid     <= 1'b1;
                    cmd_ch.command   <= current_op.kind;
                    cmd_ch.data_byte <= current_op.data;
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_frame_result want;
        res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_results.size() == 0) begin
                $display("%t: result item with none expected: outcome %0d", $realtime,
                         res_ch.outcome);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (res_ch.outcome !== want.outcome || res_ch.device_address !== want.address
                        || res_ch.function_code !== want.func
                        || res_ch.frame_length !== want.length
                        || res_ch.broadcast !== want.bcast) begin
                    $display("%t: expected outcome %0d addr %h func %h len %0d bcast %b",
                             $realtime, want.outcome, want.address, want.func, want.length,
                             want.bcast);
                    $display("%t: actual   outcome %0d addr %h func %h len %0d bcast %b",
                             $realtime, res_ch.outcome, res_ch.device_address,
                             res_ch.function_code, res_ch.frame_length, res_ch.broadcast);
                    error_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.command     = CMD_NONE;
        cmd_ch.data_byte   = 8'h00;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_SLAVE_ADDRESS;
        cfg_ch.data        = '0;
        res_ch.ready       = 1'b0;
        sender_idle_pct    = 31;
        receiver_stall_pct = 46;
        error_count        = 0;
        items_queued       = 0;
        drain_next         = 1'b0;
        model_slave_addr   = SLAVE_ADDR_RST;
        model_func_mask    = '0;
        clear_framer();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_op(CMD_POLL, 8'h00);
        push_op(CMD_NONE, 8'hFF);
        push_op(CMD_GAP, 8'hA5);
        push_op(CMD_POLL, 8'h5A);
        queue_frame(SLAVE_ADDR_RST, 8'h03, 0, 0, 0, 1'b0);
        wait_drained();

        write_reg(REG_SLAVE_ADDRESS, 64'd247);
        write_reg(REG_SUPPORTED_FUNCTIONS, {64{1'b1}});
        queue_frame(8'd247, 8'(FUNCTION_LIMIT), 0, 0, 2, 1'b0);
        push_op(CMD_BYTE, BROADCAST_ADDR);
        push_op(CMD_GAP, 8'hFF);
        push_op(CMD_POLL, 8'h00);
        wait_drained();

        write_reg(REG_SLAVE_ADDRESS, 64'($urandom_range(247, 1)));
        write_reg(REG_SUPPORTED_FUNCTIONS, {$urandom, $urandom});
        run_random_phase(31, 46, 1'b0);

        write_reg(REG_SLAVE_ADDRESS, 64'd1);
        write_reg(REG_SUPPORTED_FUNCTIONS, {$urandom, $urandom} | {$urandom, $urandom});
        drain_next = 1'b1;
        run_random_phase(46, 31, 1'b1);

        write_reg(REG_SLAVE_ADDRESS, 64'd247);
        write_reg(REG_SUPPORTED_FUNCTIONS, {64{1'b1}});
        run_random_phase(0, 0, 1'b1);

        write_reg(REG_SUPPORTED_FUNCTIONS, 64'd0);
        repeat (10) queue_random_frame();
        wait_drained();

        if (error_count == 0) begin
            $display("modbus_rtu_frame_receiver test passed");
        end else begin
            $display("modbus_rtu_frame_receiver test failed");
        end
        $finish;
    end

endmodule
